[design/utxr_pkg.sv]
`timescale 1ns / 1ps
package utxr_pkg;

  localparam int RING_SLOTS = 4096;
  localparam int PTR_W      = $clog2(RING_SLOTS);
  localparam int STAT_W     = 12;
  localparam int CMP_W      = (PTR_W > STAT_W) ? PTR_W : STAT_W;

  localparam logic [STAT_W-1:0] STAT_MAX = '1;

  localparam logic [1:0] REQ_PUT = 2'd0;
  localparam logic [1:0] REQ_GET = 2'd1;
  localparam logic [1:0] REQ_RX  = 2'd2;

  localparam logic [7:0] XON_CHAR  = 8'd17;
  localparam logic [7:0] XOFF_CHAR = 8'd19;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic              pop;
    logic              accepted;
    logic              paused;
    logic              kick;
    logic [STAT_W-1:0] fill;
    logic [STAT_W-1:0] free;
  } utxr_res_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    if (p == ptr_t'(RING_SLOTS - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

  function automatic ptr_t fill_of(input ptr_t wp, input ptr_t rp);
    logic [PTR_W:0] wrap;
    wrap = {1'b0, wp} + (PTR_W+1)'(RING_SLOTS) - {1'b0, rp};
    if (wp >= rp) begin
      return wp - rp;
    end
    return wrap[PTR_W-1:0];
  endfunction

  function automatic logic [STAT_W-1:0] sat_stat(input ptr_t v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w > CMP_W'(STAT_MAX)) begin
      return STAT_MAX;
    end
    return w[STAT_W-1:0];
  endfunction

endpackage

[design/utxr_ram.sv]
`timescale 1ns / 1ps
module utxr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/utxr_ctrl.sv]
`timescale 1ns / 1ps
module utxr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          req_type,
  input  logic [7:0]          data_byte,
  input  logic                msg_start,
  input  logic [11:0]         msg_len,
  output logic                ram_we,
  output utxr_pkg::ptr_t      ram_waddr,
  output logic [7:0]          ram_wdata,
  output utxr_pkg::ptr_t      ram_raddr,
  output utxr_pkg::utxr_res_t res,
  output logic                done
);
  import utxr_pkg::*;

  ptr_t      wp, wp_next;
  ptr_t      rp, rp_next;
  logic      pause, pause_next;
  logic      admitted, admitted_next;
  ptr_t      fill_cur, free_cur, fill_nx, free_nx;
  logic      pop, acc, kick;
  utxr_res_t res_next;

  assign fill_cur = fill_of(wp, rp);
  assign free_cur = ptr_t'(RING_SLOTS - 1) - fill_cur;

  always_comb begin
    wp_next       = wp;
    rp_next       = rp;
    pause_next    = pause;
    admitted_next = admitted;
    pop           = 1'b0;
    acc           = 1'b0;
    kick          = 1'b0;
    if (accept) begin
      unique case (req_type)
        REQ_PUT: begin
          if (msg_start) begin
            admitted_next = CMP_W'(free_cur) > CMP_W'(msg_len);
            kick          = admitted_next;
          end
          if (admitted_next && free_cur != '0) begin
            acc     = 1'b1;
            wp_next = ptr_inc(wp);
          end
        end
        REQ_GET: begin
          if (!pause && fill_cur != '0) begin
            pop     = 1'b1;
            rp_next = ptr_inc(rp);
          end
        end
        REQ_RX: begin
          if (data_byte == XON_CHAR) begin
            if (pause) begin
              pause_next = 1'b0;
              kick       = 1'b1;
            end
          end else if (data_byte == XOFF_CHAR) begin
            pause_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign fill_nx = fill_of(wp_next, rp_next);
  assign free_nx = ptr_t'(RING_SLOTS - 1) - fill_nx;

  always_comb begin
    res_next.pop      = pop;
    res_next.accepted = acc;
    res_next.paused   = pause_next;
    res_next.kick     = kick;
    res_next.fill     = sat_stat(fill_nx);
    res_next.free     = sat_stat(free_nx);
  end

  // ring write at the put transfer, read of the head slot every cycle
  assign ram_we    = acc;
  assign ram_waddr = wp;
  assign ram_wdata = data_byte;
  assign ram_raddr = rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      pause    <= 1'b0;
      admitted <= 1'b0;
      done     <= 1'b0;
    end else begin
      wp       <= wp_next;
      rp       <= rp_next;
      pause    <= pause_next;
      admitted <= admitted_next;
      done     <= accept;
    end
    res <= res_next;
  end

endmodule

[design/uart_tx_ring_with_xon_xoff.sv]
`timescale 1ns / 1ps
// Transmit byte ring with XON/XOFF flow control.
// Command channel: a transfer happens at a rising edge with start high and
// busy low. busy stays low, so one command can be issued every cycle.
// req_type selects a put of a message byte (msg_start/msg_len run the
// admission check on the first byte), a get by the transmitter, or a byte
// received from the link (XOFF pauses, XON resumes and kicks the sender).
// Result channel: done is high in the cycle after the command transfer and
// carries tx_valid/tx_byte, accepted, paused, kick_sender, fill_count and
// free_space. The rate is one command per cycle; the popped byte comes
// from the registered read port of the ring memory, read at the transfer.
// The receiver cannot stall: each result is taken in its done cycle.
// Synchronous reset empties the ring (pointers to zero), clears the pause
// and the admitted-message flag, and drops done. Ring contents are not
// cleared; only slots that were written are ever popped.
module uart_tx_ring_with_xon_xoff (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic        msg_start,
  input  logic [11:0] msg_len,
  output logic        done,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        accepted,
  output logic        paused,
  output logic        kick_sender,
  output logic [11:0] fill_count,
  output logic [11:0] free_space
);
  import utxr_pkg::*;

  logic      accept;
  logic      ram_we;
  ptr_t      ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;
  utxr_res_t res;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  utxr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .data_byte (data_byte),
    .msg_start (msg_start),
    .msg_len   (msg_len),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .res       (res),
    .done      (done)
  );

  utxr_ram #(
    .WIDTH (8),
    .DEPTH (RING_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a popped zero byte counts as end of data
  assign tx_valid    = done && res.pop && (ram_rdata != 8'h00);
  assign tx_byte     = tx_valid ? ram_rdata : 8'h00;
  assign accepted    = res.accepted;
  assign paused      = res.paused;
  assign kick_sender = res.kick;
  assign fill_count  = res.fill;
  assign free_space  = res.free;

  a_done_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start))
    else $error("result strobe without a command transfer");

  a_valid_in_done: assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> done && !accepted)
    else $error("tx_valid outside a get result");

  a_put_fills: assert property (@(posedge clk) disable iff (rst)
    done && accepted |-> fill_count != '0)
    else $error("stored byte but ring reports empty");

  a_pause_no_pop: assert property (@(posedge clk) disable iff (rst)
    done && res.pop |-> !paused)
    else $error("byte popped while paused");

endmodule

[dv/uart_tx_ring_with_xon_xoff_tb.sv]
`timescale 1ns / 1ps
module uart_tx_ring_with_xon_xoff_tb;
  import utxr_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        accepted;
    logic        paused;
    logic        kick;
    logic [11:0] fill;
    logic [11:0] free;
  } status_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  data;
    logic        first;
    logic [11:0] len;
    logic        typed;
    status_t     want;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = REQ_NONE;
  logic [7:0]  data_byte = '0;
  logic        msg_start = 1'b0;
  logic [11:0] msg_len = '0;
  logic        done;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        accepted;
  logic        paused;
  logic        kick_sender;
  logic [11:0] fill_count;
  logic [11:0] free_space;

  logic [7:0] ring_mem [RING_SLOTS];
  int         wr_idx = 0;
  int         rd_idx = 0;
  bit         xoff_held = 0;
  bit         msg_ok = 0;

  status_t pending_status [$];
  int      fail_count = 0;
  int      quiet_cycles = 0;
  int      items_sent = 0;
  bit      idle_on = 1;

  stim_row_t dir_rows [23] = '{
    '{REQ_GET,  8'h00, 0, 12'd0,    1, '{0, 8'h00, 0, 0, 0, 12'd0, 12'd4095}},
    '{REQ_PUT,  8'hff, 0, 12'd0,    1, '{0, 8'h00, 0, 0, 0, 12'd0, 12'd4095}},
    '{REQ_PUT,  8'haa, 1, 12'd4095, 1, '{0, 8'h00, 0, 0, 0, 12'd0, 12'd4095}},
    '{REQ_PUT,  8'h00, 1, 12'd0,    1, '{0, 8'h00, 1, 0, 1, 12'd1, 12'd4094}},
    '{REQ_PUT,  8'hff, 0, 12'hfff,  0, '0},
    '{REQ_PUT,  8'h01, 0, 12'habc,  0, '0},
    '{REQ_RX,   XON_CHAR, 0, 12'd0, 0, '0},
    '{REQ_RX,   XOFF_CHAR, 0, 12'd0, 0, '0},
    '{REQ_GET,  8'h00, 0, 12'd0,    0, '0},
    '{REQ_RX,   8'hff, 1, 12'hfff,  0, '0},
    '{REQ_RX,   XON_CHAR, 0, 12'd0, 0, '0},
    '{REQ_GET,  8'h00, 0, 12'd0,    1, '{0, 8'h00, 0, 0, 0, 12'd2, 12'd4093}},
    '{REQ_GET,  8'hff, 1, 12'hfff,  1, '{1, 8'hff, 0, 0, 0, 12'd1, 12'd4094}},
    '{REQ_GET,  8'h00, 0, 12'd0,    0, '0},
    '{REQ_GET,  8'h00, 0, 12'd0,    0, '0},
    '{REQ_NONE, 8'hff, 1, 12'd4095, 1, '{0, 8'h00, 0, 0, 0, 12'd0, 12'd4095}},
    '{REQ_PUT,  8'h80, 1, 12'd4094, 1, '{0, 8'h00, 1, 0, 1, 12'd1, 12'd4094}},
    '{REQ_GET,  8'h00, 0, 12'd0,    0, '0},
    '{REQ_RX,   XOFF_CHAR, 0, 12'd0, 0, '0},
    '{REQ_PUT,  8'h55, 1, 12'd10,   0, '0},
    '{REQ_RX,   XON_CHAR, 0, 12'd0, 0, '0},
    '{REQ_GET,  8'h00, 0, 12'd0,    0, '0},
    '{REQ_RX,   8'h00, 0, 12'd0,    0, '0}
  };

  uart_tx_ring_with_xon_xoff dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .data_byte   (data_byte),
    .msg_start   (msg_start),
    .msg_len     (msg_len),
    .done        (done),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .accepted    (accepted),
    .paused      (paused),
    .kick_sender (kick_sender),
    .fill_count  (fill_count),
    .free_space  (free_space)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int ring_fill();
    return (wr_idx + RING_SLOTS - rd_idx) % RING_SLOTS;
  endfunction

  function automatic logic [11:0] clamp12(int v);
    return (v > 4095) ? 12'd4095 : 12'(v);
  endfunction

  function automatic status_t predict_status(logic [1:0] req, logic [7:0] data,
                                             logic first, logic [11:0] len);
    status_t s;
    logic [7:0] b;
    s = '0;
    case (req)
      REQ_PUT: begin
        if (first) begin
          msg_ok = (RING_SLOTS - 1 - ring_fill()) > int'(len);
          s.kick = msg_ok;
        end
        if (msg_ok && (RING_SLOTS - 1 - ring_fill()) > 0) begin
          ring_mem[wr_idx] = data;
          wr_idx = (wr_idx + 1) % RING_SLOTS;
          s.accepted = 1'b1;
        end
      end
      REQ_GET: begin
        if (!xoff_held && ring_fill() > 0) begin
          b = ring_mem[rd_idx];
          rd_idx = (rd_idx + 1) % RING_SLOTS;
          if (b != 8'd0) begin
            s.tx_valid = 1'b1;
            s.tx_byte  = b;
          end
        end
      end
      REQ_RX: begin
        if (data == XON_CHAR) begin
          if (xoff_held) begin
            xoff_held = 0;
            s.kick    = 1'b1;
          end
        end else if (data == XOFF_CHAR) begin
          xoff_held = 1;
        end
      end
      default: ;
    endcase
    s.paused = xoff_held;
    s.fill   = clamp12(ring_fill());
    s.free   = clamp12(RING_SLOTS - 1 - ring_fill());
    return s;
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) begin
      return 8'd0;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_cmd(input logic [1:0] req, input logic [7:0] data,
                          input logic first, input logic [11:0] len,
                          input bit typed = 0, input status_t given = '0);
    status_t s;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start     <= 1'b1;
    req_type  <= req;
    data_byte <= data;
    msg_start <= first;
    msg_len   <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    s = predict_status(req, data, first, len);
    pending_status.push_back(typed ? given : s);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic run_random(int count);
    int target;
    int pick;
    int nbytes;
    logic [11:0] len;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                          : 12'($urandom_range(1, 24));
        nbytes = (len > 24) ? $urandom_range(1, 6) : ((len == 0) ? 1 : int'(len));
        if ($urandom_range(0, 9) == 0) begin
          nbytes = $urandom_range(1, nbytes);
        end
        for (int i = 0; i < nbytes; i++) begin
          send_cmd(REQ_PUT, rand_byte(), i == 0, (i == 0) ? len : 12'($urandom));
          if ($urandom_range(0, 2) == 0) begin
            send_cmd(REQ_GET, 8'($urandom), 1'($urandom), 12'($urandom));
          end
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 8)) begin
          send_cmd(REQ_GET, 8'($urandom), 1'($urandom), 12'($urandom));
        end
      end else if (pick < 88) begin
        send_cmd(REQ_RX, ($urandom_range(0, 2) == 0) ? XOFF_CHAR : XON_CHAR,
                 1'($urandom), 12'($urandom));
      end else if (pick < 93) begin
        send_cmd(REQ_RX, 8'($urandom), 1'($urandom), 12'($urandom));
      end else if (pick < 97) begin
        send_cmd(REQ_PUT, rand_byte(), 1'b0, 12'($urandom));
      end else begin
        send_cmd(REQ_NONE, 8'($urandom), 1'($urandom), 12'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (done) begin
        if (pending_status.size() == 0) begin
          $error("result with no transfer pending");
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          check_field("tx_valid", want.tx_valid, tx_valid);
          check_field("tx_byte", want.tx_byte, tx_byte);
          check_field("accepted", want.accepted, accepted);
          check_field("paused", want.paused, paused);
          check_field("kick_sender", want.kick, kick_sender);
          check_field("fill_count", want.fill, fill_count);
          check_field("free_space", want.free, free_space);
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** uart_tx_ring_with_xon_xoff: FAILED **");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].req, dir_rows[i].data, dir_rows[i].first, dir_rows[i].len,
               dir_rows[i].typed, dir_rows[i].want);
    end

    run_random(900);

    // admission exactly at the free-space boundary, then a bounded drain
    drain_results();
    send_cmd(REQ_PUT, rand_byte(), 1'b1, 12'(RING_SLOTS - 1 - ring_fill()));
    send_cmd(REQ_PUT, rand_byte(), 1'b0, 12'($urandom));
    send_cmd(REQ_PUT, rand_byte(), 1'b1, 12'(RING_SLOTS - 2 - ring_fill()));
    send_cmd(REQ_PUT, rand_byte(), 1'b0, 12'($urandom));
    send_cmd(REQ_RX, XON_CHAR, 1'b0, 12'd0);
    for (int i = 0; i < 64 && ring_fill() > 0; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_cmd(REQ_RX, XOFF_CHAR, 1'($urandom), 12'($urandom));
        send_cmd(REQ_GET, 8'($urandom), 1'($urandom), 12'($urandom));
        send_cmd(REQ_RX, XON_CHAR, 1'($urandom), 12'($urandom));
      end
      send_cmd(REQ_GET, 8'($urandom), 1'($urandom), 12'($urandom));
    end

    idle_on = 0;
    run_random(200);

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("** uart_tx_ring_with_xon_xoff: PASSED **");
    end else begin
      $display("** uart_tx_ring_with_xon_xoff: FAILED **");
    end
    $finish;
  end

endmodule

[uart_tx_ring_with_xon_xoff.f]
design/utxr_pkg.sv
design/utxr_ram.sv
design/utxr_ctrl.sv
design/uart_tx_ring_with_xon_xoff.sv
dv/uart_tx_ring_with_xon_xoff_tb.sv
